>>> src/i2c_master_bit_engine_unit_macros.svh
// Assertion macros shared by the I2C master bit engine modules.
// Depends on nothing; each user passes its own clock and reset.
`ifndef I2C_MASTER_BIT_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/i2cm_pkg.sv
// Package of the I2C master bit engine: command codes, item types and helpers.
// Used by the queue, the front, the back and the top level.
package i2cm_pkg;

    localparam int CNT_W = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [32:0] CNT_MAX = (33'd1 << CNT_W) - 33'd1;
    localparam logic [15:0] PHASE_TICKS_RESET = 16'd10;
    localparam logic [2:0] LAST_BIT = 3'd7;
    localparam int MSB_POS = 7;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_STOP    = 3'd2,
        CMD_WRITE   = 3'd3,
        CMD_READ    = 3'd4,
        CMD_WAITACK = 3'd5,
        CMD_ACK     = 3'd6,
        CMD_NACK    = 3'd7
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic       has_cmd;
        logic [7:0] wr_byte;
        logic       sda_in;
    } q_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rd_byte;
        logic       ack_level;
        logic       cmd_rejected;
    } res_t;

    function automatic logic [CNT_W-1:0] phase_limit(input logic [15:0] pt);
        logic [32:0] ext;
        ext = 33'(pt);
        if (ext == 33'd0)
        begin
            ext = 33'd1;
        end
        if (ext > CNT_MAX)
        begin
            ext = CNT_MAX;
        end
        return ext[CNT_W-1:0];
    endfunction

    function automatic logic [4:0] phase_count(input cmd_t cmd);
        case (cmd)
            CMD_STOP:  return 5'd1;
            CMD_WRITE: return 5'd24;
            CMD_READ:  return 5'd16;
            default:   return 5'd3;
        endcase
    endfunction

    // Bit index of a write phase: the phase divided by three, by reciprocal.
    function automatic logic [2:0] wr_bit_index(input logic [4:0] p);
        logic [8:0] prod;
        prod = 9'(p) * 9'd11;
        return prod[7:5];
    endfunction

    function automatic logic [1:0] wr_sub_phase(input logic [4:0] p);
        logic [4:0] base;
        base = 5'(wr_bit_index(p)) * 5'd3;
        return 2'(p - base);
    endfunction

endpackage

>>> src/i2cm_if.sv
// Channel interfaces of the I2C master bit engine: request, result and configuration.
// Depends on nothing; the field widths are written out in each interface.
interface i2cm_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [7:0] wr_byte;
    logic       sda_in;

    modport source (output valid, output req_type, output wr_byte, output sda_in,
                    input ready);
    modport sink (input valid, input req_type, input wr_byte, input sda_in,
                  output ready);
endinterface

interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rd_byte;
    logic       ack_level;
    logic       cmd_rejected;

    modport source (output valid, output scl_out, output sda_out, output busy_res,
                    output done_res, output rd_byte, output ack_level,
                    output cmd_rejected, input ready);
    modport sink (input valid, input scl_out, input sda_out, input busy_res,
                  input done_res, input rd_byte, input ack_level,
                  input cmd_rejected, output ready);
endinterface

interface i2cm_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] phase_ticks;

    modport source (output valid, output phase_ticks, input ready);
    modport sink (input valid, input phase_ticks, output ready);
endinterface

>>> src/i2c_master_bit_engine_unit.sv
// When the queue is empty, an accepted item is queued, then popped and stepped by the phase
// sequencer, which registers its result in the output register from which it is taken.
// Throughput: one item per cycle while results are taken; a result left waiting stalls the pop.
// The two-entry queue lets the front accept while a result waits to be taken.
// Reset clears the queue and the sequencer, releases SCL and SDA, sets phase_ticks to 10.
// Top level of the I2C master bit engine: front, queue and back wired to the channels.
// Depends on i2cm_pkg, the channel interfaces, i2cm_front and i2cm_back.
module i2c_master_bit_engine_unit (
    input  logic       clk,
    input  logic       rst_n,
    i2cm_req_if.sink   req_ch,
    i2cm_res_if.source res_ch,
    i2cm_cfg_if.sink   cfg_ch
);

    logic              q_valid;
    i2cm_pkg::q_item_t q_item;
    logic              pop;

    i2cm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req_ch  (req_ch),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop)
    );

    i2cm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop),
        .res_ch  (res_ch),
        .cfg_ch  (cfg_ch)
    );

endmodule

>>> src/i2cm_fifo.sv
// Short queue of classified items between the front and the back of the engine.
// Depends on i2cm_pkg for the item type and the queue depth.
module i2cm_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  i2cm_pkg::q_item_t push_item,
    output logic              full,
    output logic              q_valid,
    output i2cm_pkg::q_item_t q_item,
    input  logic              pop
);

    i2cm_pkg::q_item_t                  store_reg [i2cm_pkg::QUEUE_DEPTH];
    logic [i2cm_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [i2cm_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [i2cm_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [i2cm_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [i2cm_pkg::QCNT_W-1:0]        count_reg;
    logic [i2cm_pkg::QCNT_W-1:0]        count_next;
    logic                               do_push;
    logic                               do_pop;

    assign full     = (count_reg == i2cm_pkg::QCNT_W'(i2cm_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = store_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == i2cm_pkg::QPTR_W'(i2cm_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == i2cm_pkg::QPTR_W'(i2cm_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> src/i2cm_front.sv
// Front of the engine: accepts request items, classifies the command and queues them.
// Depends on i2cm_pkg, the request interface and i2cm_fifo.
module i2cm_front (
    input  logic              clk,
    input  logic              rst_n,
    i2cm_req_if.sink          req_ch,
    output logic              q_valid,
    output i2cm_pkg::q_item_t q_item,
    input  logic              pop
);

    i2cm_pkg::q_item_t class_item;
    logic              full;

    always_comb
    begin
        class_item.cmd     = i2cm_pkg::cmd_t'(req_ch.req_type);
        class_item.has_cmd = (req_ch.req_type != 3'(i2cm_pkg::CMD_NONE));
        class_item.wr_byte = req_ch.wr_byte;
        class_item.sda_in  = req_ch.sda_in;
    end

    assign req_ch.ready = !full;

    i2cm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req_ch.valid),
        .push_item (class_item),
        .full      (full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop)
    );

endmodule

>>> src/i2cm_back.sv
// Back of the engine: steps the bus phase sequencer once per item and registers results.
// Depends on i2cm_pkg, the result and configuration interfaces and the assertion macros.
`include "i2c_master_bit_engine_unit_macros.svh"

module i2cm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  i2cm_pkg::q_item_t q_item,
    output logic              pop,
    i2cm_res_if.source        res_ch,
    i2cm_cfg_if.sink          cfg_ch
);

    i2cm_pkg::cmd_t                active_reg;
    i2cm_pkg::cmd_t                active_next;
    logic [4:0]                    phase_reg;
    logic [4:0]                    phase_next;
    logic [i2cm_pkg::CNT_W-1:0]    tick_reg;
    logic [i2cm_pkg::CNT_W-1:0]    tick_next;
    logic [7:0]                    shift_reg;
    logic [7:0]                    shift_next;
    logic                          scl_reg;
    logic                          scl_next;
    logic                          sda_reg;
    logic                          sda_next;
    logic                          ack_reg;
    logic                          ack_next;
    logic [7:0]                    hold_reg;
    logic [7:0]                    hold_next;
    logic [15:0]                   phase_ticks_reg;
    logic                          out_valid_reg;
    i2cm_pkg::res_t                out_reg;
    logic                          done;
    logic                          rejected;
    logic [i2cm_pkg::CNT_W-1:0]    limit;
    logic [1:0]                    sub;

    assign cfg_ch.ready = 1'b1;
    assign pop          = q_valid && (!out_valid_reg || res_ch.ready);
    assign limit        = i2cm_pkg::phase_limit(phase_ticks_reg);

    always_comb
    begin
        active_next = active_reg;
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        shift_next  = shift_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        ack_next    = ack_reg;
        hold_next   = hold_reg;
        done        = 1'b0;
        rejected    = 1'b0;
        sub         = 2'd0;
        if (active_reg == i2cm_pkg::CMD_NONE)
        begin
            if (q_item.has_cmd)
            begin
                active_next = q_item.cmd;
                phase_next  = 5'd0;
                tick_next   = '0;
                shift_next  = (q_item.cmd == i2cm_pkg::CMD_WRITE) ? q_item.wr_byte : 8'd0;
            end
        end
        else
        begin
            rejected  = q_item.has_cmd;
            tick_next = tick_reg + 1'b1;
            if (tick_next >= limit)
            begin
                if (active_reg == i2cm_pkg::CMD_READ && !phase_reg[0])
                begin
                    shift_next = {shift_reg[6:0], q_item.sda_in};
                end
                else if (active_reg == i2cm_pkg::CMD_WAITACK && phase_reg == 5'd1)
                begin
                    ack_next = q_item.sda_in;
                end
                tick_next  = '0;
                phase_next = phase_reg + 1'b1;
                if (phase_next >= i2cm_pkg::phase_count(active_reg))
                begin
                    if (active_reg == i2cm_pkg::CMD_STOP || active_reg == i2cm_pkg::CMD_ACK)
                    begin
                        sda_next = 1'b1;
                    end
                    else if (active_reg == i2cm_pkg::CMD_READ)
                    begin
                        hold_next = shift_next;
                    end
                    active_next = i2cm_pkg::CMD_NONE;
                    phase_next  = 5'd0;
                    done        = 1'b1;
                end
            end
        end

        // Levels of the phase being entered, both for a new command and a phase change.
        if (active_next != i2cm_pkg::CMD_NONE && !done &&
            (active_reg == i2cm_pkg::CMD_NONE || tick_next == '0))
        begin
            case (active_next)
                i2cm_pkg::CMD_START:
                begin
                    if (phase_next == 5'd0)
                    begin
                        sda_next = 1'b1;
                        scl_next = 1'b1;
                    end
                    else if (phase_next == 5'd1)
                    begin
                        sda_next = 1'b0;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                    end
                end
                i2cm_pkg::CMD_STOP:
                begin
                    sda_next = 1'b0;
                    scl_next = 1'b1;
                end
                i2cm_pkg::CMD_WRITE:
                begin
                    sub = i2cm_pkg::wr_sub_phase(phase_next);
                    if (sub == 2'd0)
                    begin
                        sda_next = shift_next[i2cm_pkg::MSB_POS];
                    end
                    else if (sub == 2'd1)
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                        if (i2cm_pkg::wr_bit_index(phase_next) == i2cm_pkg::LAST_BIT)
                        begin
                            sda_next = 1'b1;
                        end
                        shift_next = {shift_next[6:0], 1'b0};
                    end
                end
                i2cm_pkg::CMD_READ:
                begin
                    scl_next = !phase_next[0];
                end
                default:
                begin
                    if (phase_next == 5'd0)
                    begin
                        sda_next = (active_next != i2cm_pkg::CMD_ACK);
                    end
                    else if (phase_next == 5'd1)
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= i2cm_pkg::CMD_NONE;
            phase_reg       <= 5'd0;
            tick_reg        <= '0;
            shift_reg       <= 8'd0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            ack_reg         <= 1'b1;
            hold_reg        <= 8'd0;
            phase_ticks_reg <= i2cm_pkg::PHASE_TICKS_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                phase_ticks_reg <= cfg_ch.phase_ticks;
            end
            if (pop)
            begin
                active_reg    <= active_next;
                phase_reg     <= phase_next;
                tick_reg      <= tick_next;
                shift_reg     <= shift_next;
                scl_reg       <= scl_next;
                sda_reg       <= sda_next;
                ack_reg       <= ack_next;
                hold_reg      <= hold_next;
                out_valid_reg <= 1'b1;
            end
            else if (res_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg.scl_out      <= scl_next;
            out_reg.sda_out      <= sda_next;
            out_reg.busy_res     <= (active_next != i2cm_pkg::CMD_NONE);
            out_reg.done_res     <= done;
            out_reg.rd_byte      <= hold_next;
            out_reg.ack_level    <= ack_next;
            out_reg.cmd_rejected <= rejected;
        end
    end

    assign res_ch.valid        = out_valid_reg;
    assign res_ch.scl_out      = out_reg.scl_out;
    assign res_ch.sda_out      = out_reg.sda_out;
    assign res_ch.busy_res     = out_reg.busy_res;
    assign res_ch.done_res     = out_reg.done_res;
    assign res_ch.rd_byte      = out_reg.rd_byte;
    assign res_ch.ack_level    = out_reg.ack_level;
    assign res_ch.cmd_rejected = out_reg.cmd_rejected;

    `I2CM_ASSERT_NOW(a_idle_counters_clear, clk, rst_n,
        active_reg == i2cm_pkg::CMD_NONE, tick_reg == '0 && phase_reg == 5'd0,
        "Idle engine holds a nonzero phase or tick count.")
    `I2CM_ASSERT_NOW(a_phase_in_range, clk, rst_n,
        1'b1, phase_reg < i2cm_pkg::phase_count(active_reg),
        "Phase index beyond the command's last phase.")
    `I2CM_ASSERT_NEXT(a_done_leaves_idle, clk, rst_n,
        pop && done, active_reg == i2cm_pkg::CMD_NONE && !out_reg.busy_res,
        "Completed command left the engine busy.")
    `I2CM_ASSERT_NEXT(a_reject_only_busy, clk, rst_n,
        pop && active_reg == i2cm_pkg::CMD_NONE, !out_reg.cmd_rejected,
        "Command flagged as rejected while the engine was idle.")

endmodule

>>> bench/tb.sv
// Self-checking testbench for the I2C master bit engine, with its own model of the bus phases.
// Depends on i2cm_pkg, the channel interfaces and i2c_master_bit_engine_unit.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 100000;
    localparam int RANDOM_PHASES = 6;
    localparam int CMDS_PER_PHASE = 6;

    typedef struct {
        i2cm_pkg::cmd_t kind;
        logic [7:0]     wr;
        logic           sda;
    } bus_tick_t;

    logic clk = 1'b0;
    logic rst_n;

    i2cm_req_if req_ch();
    i2cm_res_if res_ch();
    i2cm_cfg_if cfg_ch();

    i2c_master_bit_engine_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_ch(req_ch),
        .res_ch(res_ch),
        .cfg_ch(cfg_ch)
    );

    bus_tick_t      pending_ticks[$];
    i2cm_pkg::res_t bus_outputs_due[$];
    i2cm_pkg::res_t oldest_due;
    bus_tick_t      next_tick;
    logic           req_taken = 1'b0;
    int             src_idle_pct = 0;
    int             snk_stall_pct = 0;
    int             gen_limit = 10;
    int             mismatches = 0;
    int             cycles = 0;
    int             tick_plan[RANDOM_PHASES] = '{1, 0, 2, 3, 1, 1};

    logic [15:0]    eng_ticks = i2cm_pkg::PHASE_TICKS_RESET;
    i2cm_pkg::cmd_t eng_cmd = i2cm_pkg::CMD_NONE;
    logic [4:0]     eng_phase = 5'd0;
    logic [15:0]    eng_count = 16'd0;
    logic [7:0]     eng_shift = 8'd0;
    logic           eng_scl = 1'b1;
    logic           eng_sda = 1'b1;
    logic           eng_ack = 1'b1;
    logic [7:0]     eng_read = 8'd0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int phases_of(input i2cm_pkg::cmd_t c);
        case (c)
            i2cm_pkg::CMD_STOP:  return 1;
            i2cm_pkg::CMD_WRITE: return 24;
            i2cm_pkg::CMD_READ:  return 16;
            default:             return 3;
        endcase
    endfunction

    function automatic void enter_bus_phase(input logic [4:0] p);
        case (eng_cmd)
            i2cm_pkg::CMD_START:
            begin
                if (p == 5'd0)
                begin
                    eng_sda = 1'b1;
                    eng_scl = 1'b1;
                end
                else if (p == 5'd1)
                    eng_sda = 1'b0;
                else
                    eng_scl = 1'b0;
            end
            i2cm_pkg::CMD_STOP:
            begin
                eng_sda = 1'b0;
                eng_scl = 1'b1;
            end
            i2cm_pkg::CMD_WRITE:
            begin
                if (p % 3 == 0)
                    eng_sda = eng_shift[7];
                else if (p % 3 == 1)
                    eng_scl = 1'b1;
                else
                begin
                    eng_scl = 1'b0;
                    if (p / 3 == 7)
                        eng_sda = 1'b1;
                    eng_shift = {eng_shift[6:0], 1'b0};
                end
            end
            i2cm_pkg::CMD_READ:
                eng_scl = ~p[0];
            default:
            begin
                if (p == 5'd0)
                    eng_sda = (eng_cmd == i2cm_pkg::CMD_ACK) ? 1'b0 : 1'b1;
                else if (p == 5'd1)
                    eng_scl = 1'b1;
                else
                    eng_scl = 1'b0;
            end
        endcase
    endfunction

    function automatic i2cm_pkg::res_t advance_bus_model(input i2cm_pkg::cmd_t req,
                                                         input logic [7:0] wr,
                                                         input logic sda);
        i2cm_pkg::res_t r;
        logic           rejected;
        logic           done;
        logic [15:0]    lim;
        rejected = 1'b0;
        done = 1'b0;
        if (eng_cmd == i2cm_pkg::CMD_NONE)
        begin
            if (req != i2cm_pkg::CMD_NONE)
            begin
                eng_cmd = req;
                eng_phase = 5'd0;
                eng_count = 16'd0;
                eng_shift = (req == i2cm_pkg::CMD_WRITE) ? wr : 8'd0;
                enter_bus_phase(5'd0);
            end
        end
        else
        begin
            if (req != i2cm_pkg::CMD_NONE)
                rejected = 1'b1;
            lim = (eng_ticks == 16'd0) ? 16'd1 : eng_ticks;
            eng_count = eng_count + 16'd1;
            if (eng_count >= lim)
            begin
                if (eng_cmd == i2cm_pkg::CMD_READ && !eng_phase[0])
                    eng_shift = {eng_shift[6:0], sda};
                else if (eng_cmd == i2cm_pkg::CMD_WAITACK && eng_phase == 5'd1)
                    eng_ack = sda;
                eng_count = 16'd0;
                eng_phase = eng_phase + 5'd1;
                if (int'(eng_phase) >= phases_of(eng_cmd))
                begin
                    if (eng_cmd == i2cm_pkg::CMD_STOP || eng_cmd == i2cm_pkg::CMD_ACK)
                        eng_sda = 1'b1;
                    else if (eng_cmd == i2cm_pkg::CMD_READ)
                        eng_read = eng_shift;
                    eng_cmd = i2cm_pkg::CMD_NONE;
                    eng_phase = 5'd0;
                    done = 1'b1;
                end
                else
                    enter_bus_phase(eng_phase);
            end
        end
        r.scl_out = eng_scl;
        r.sda_out = eng_sda;
        r.busy_res = (eng_cmd != i2cm_pkg::CMD_NONE);
        r.done_res = done;
        r.rd_byte = eng_read;
        r.ack_level = eng_ack;
        r.cmd_rejected = rejected;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else if (rst_n === 1'b1)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                bus_outputs_due.push_back(advance_bus_model(
                    i2cm_pkg::cmd_t'(req_ch.req_type), req_ch.wr_byte, req_ch.sda_in));
                req_taken = 1'b1;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (bus_outputs_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %0h", $time,
                             {res_ch.scl_out, res_ch.sda_out, res_ch.busy_res,
                              res_ch.done_res, res_ch.rd_byte, res_ch.ack_level,
                              res_ch.cmd_rejected});
                    mismatches++;
                end
                else
                begin
                    oldest_due = bus_outputs_due.pop_front();
                    check_field("scl_out", 8'(oldest_due.scl_out), 8'(res_ch.scl_out));
                    check_field("sda_out", 8'(oldest_due.sda_out), 8'(res_ch.sda_out));
                    check_field("busy_res", 8'(oldest_due.busy_res), 8'(res_ch.busy_res));
                    check_field("done_res", 8'(oldest_due.done_res), 8'(res_ch.done_res));
                    check_field("rd_byte", oldest_due.rd_byte, res_ch.rd_byte);
                    check_field("ack_level", 8'(oldest_due.ack_level), 8'(res_ch.ack_level));
                    check_field("cmd_rejected", 8'(oldest_due.cmd_rejected),
                                8'(res_ch.cmd_rejected));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (!req_ch.valid || req_taken)
            begin
                if (pending_ticks.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    next_tick = pending_ticks.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.req_type <= next_tick.kind;
                    req_ch.wr_byte <= next_tick.wr;
                    req_ch.sda_in <= next_tick.sda;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                    req_ch.req_type <= 3'($urandom);
                    req_ch.wr_byte <= 8'($urandom);
                    req_ch.sda_in <= 1'($urandom);
                end
            end
            req_taken = 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n === 1'b1)
            res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic push_tick(input i2cm_pkg::cmd_t kind, input logic [7:0] wr,
                             input int sda_fix);
        bus_tick_t t;
        t.kind = kind;
        t.wr = wr;
        t.sda = (sda_fix < 0) ? 1'($urandom_range(1)) : sda_fix[0];
        pending_ticks.push_back(t);
    endtask

    task automatic add_cmd(input i2cm_pkg::cmd_t c, input logic [7:0] wr, input int noise_pct,
                           input bit reject_at_end, input int sda_fix);
        int             span;
        i2cm_pkg::cmd_t kind;
        span = phases_of(c) * gen_limit;
        push_tick(c, wr, sda_fix);
        for (int i = 1; i <= span; i++)
        begin
            kind = i2cm_pkg::CMD_NONE;
            if ($urandom_range(99) < noise_pct || (reject_at_end && i == span))
                kind = i2cm_pkg::cmd_t'($urandom_range(7, 1));
            push_tick(kind, 8'($urandom), sda_fix);
        end
    endtask

    task automatic settle();
        while (pending_ticks.size() != 0 || req_ch.valid || bus_outputs_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_phase_ticks(input logic [15:0] v);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.phase_ticks <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        eng_ticks = v;
        gen_limit = (v == 16'd0) ? 1 : int'(v);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 78; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 78; end
            default: begin src_idle_pct = 7; snk_stall_pct = 7; end
        endcase
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = i2cm_pkg::CMD_NONE;
        req_ch.wr_byte = 8'd0;
        req_ch.sda_in = 1'b1;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.phase_ticks = 16'd0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The reset phase length of ten is used first, without any write.
        set_idling(0);
        add_cmd(i2cm_pkg::CMD_START, 8'h00, 0, 0, -1);
        add_cmd(i2cm_pkg::CMD_WAITACK, 8'h5A, 0, 0, 0);
        add_cmd(i2cm_pkg::CMD_STOP, 8'h00, 0, 1, -1);
        settle();

        set_phase_ticks(16'd1);
        add_cmd(i2cm_pkg::CMD_WRITE, 8'hFF, 0, 0, -1);
        add_cmd(i2cm_pkg::CMD_WRITE, 8'h00, 0, 0, -1);
        add_cmd(i2cm_pkg::CMD_WAITACK, 8'h5A, 0, 0, 0);
        add_cmd(i2cm_pkg::CMD_WAITACK, 8'hA5, 0, 0, 1);
        add_cmd(i2cm_pkg::CMD_READ, 8'h00, 0, 0, 1);
        add_cmd(i2cm_pkg::CMD_READ, 8'hFF, 0, 0, 0);
        add_cmd(i2cm_pkg::CMD_READ, 8'h3C, 0, 0, -1);
        add_cmd(i2cm_pkg::CMD_ACK, 8'h00, 0, 0, -1);
        add_cmd(i2cm_pkg::CMD_NACK, 8'h00, 0, 0, -1);
        add_cmd(i2cm_pkg::CMD_WRITE, 8'hA5, 30, 0, -1);
        add_cmd(i2cm_pkg::CMD_START, 8'hC3, 0, 1, -1);
        add_cmd(i2cm_pkg::CMD_STOP, 8'h00, 0, 1, -1);
        push_tick(i2cm_pkg::CMD_NONE, 8'hFF, 0);
        settle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            set_phase_ticks(16'(tick_plan[ph]));
            set_idling(ph);
            repeat (CMDS_PER_PHASE)
            begin
                add_cmd(i2cm_pkg::cmd_t'($urandom_range(7, 1)), 8'($urandom),
                        ($urandom_range(99) < 30) ? 15 : 0, ($urandom_range(99) < 10), -1);
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(3))
                        push_tick(i2cm_pkg::CMD_NONE, 8'($urandom), -1);
            end
            settle();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0 && bus_outputs_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/i2cm_pkg.sv
src/i2cm_if.sv
src/i2cm_fifo.sv
src/i2cm_front.sv
src/i2cm_back.sv
src/i2c_master_bit_engine_unit.sv
bench/tb.sv
